@@ rtl/mip_pkg.sv @@
// Shared types and constants for the MessagePack integer packer.
// Holds the descriptor passed from the classifier to the byte sequencer.
// No dependencies.
`default_nettype none

package mip_pkg;

	localparam logic [2:0] KIND_UINT     = 3'd0;
	localparam logic [2:0] KIND_SINT     = 3'd1;
	localparam logic [2:0] KIND_ARRAY    = 3'd2;
	localparam logic [2:0] KIND_RAW_HDR  = 3'd3;
	localparam logic [2:0] KIND_RAW_BYTE = 3'd4;

	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;
	localparam logic [1:0] WC_64 = 2'd3;

	localparam logic [7:0] TAG_UINT8  = 8'hcc;
	localparam logic [7:0] TAG_UINT16 = 8'hcd;
	localparam logic [7:0] TAG_UINT32 = 8'hce;
	localparam logic [7:0] TAG_UINT64 = 8'hcf;
	localparam logic [7:0] TAG_INT8   = 8'hd0;
	localparam logic [7:0] TAG_INT16  = 8'hd1;
	localparam logic [7:0] TAG_INT32  = 8'hd2;
	localparam logic [7:0] TAG_INT64  = 8'hd3;
	localparam logic [7:0] TAG_FIXARRAY = 8'h90;
	localparam logic [7:0] TAG_FIXRAW   = 8'ha0;
	localparam logic [7:0] FIXARRAY_MASK = 8'h0F;
	localparam logic [7:0] FIXRAW_MASK   = 8'h1F;

	localparam logic [15:0] CAPACITY_RESET = 16'd256;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_COUNT = 2'd2
	} status_t;

	typedef enum logic {
		PH_START,
		PH_PAYLOAD
	} phase_t;

	// One classified request: either a bare status result, or an optional tag
	// followed by a big-endian payload of 1, 2, 4 or 8 bytes.
	typedef struct packed {
		logic        is_status;
		status_t     status;
		logic        has_tag;
		logic [7:0]  tag;
		logic [1:0]  len_code;
		logic [63:0] payload;
	} desc_t;

	typedef struct packed {
		logic  push;
		desc_t desc;
	} q_wr_t;

	typedef struct packed {
		logic  valid;
		desc_t desc;
	} q_rd_t;

endpackage

`default_nettype wire

@@ rtl/mip_front.sv @@
// Front end of the packer: accepts requests and classifies them into descriptors.
// Depends on mip_pkg.
`default_nettype none

module mip_front (
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire  [79:0]       s_tdata,
	input  wire  [2:0]        s_tuser,
	input  wire               q_full,
	output mip_pkg::q_wr_t    q_wr
);
	import mip_pkg::*;

	logic [1:0]  wc;
	logic [63:0] val;
	logic [7:0]  cnt;
	logic [63:0] raw;
	logic [63:0] ext;
	logic        sign;
	desc_t       d;
	desc_t       du;

	assign wc  = s_tdata[1:0];
	assign val = s_tdata[65:2];
	assign cnt = s_tdata[73:66];

	always_comb begin
		case (wc)
			WC_8: begin
				raw  = {56'd0, val[7:0]};
				sign = val[7];
				ext  = {{56{val[7]}}, val[7:0]};
			end
			WC_16: begin
				raw  = {48'd0, val[15:0]};
				sign = val[15];
				ext  = {{48{val[15]}}, val[15:0]};
			end
			WC_32: begin
				raw  = {32'd0, val[31:0]};
				sign = val[31];
				ext  = {{32{val[31]}}, val[31:0]};
			end
			default: begin
				raw  = val;
				sign = val[63];
				ext  = val;
			end
		endcase
	end

	// Smallest unsigned form of the masked value.
	always_comb begin
		du           = '0;
		du.status    = ST_OK;
		du.payload   = raw;
		if (raw[63:7] == 57'd0) begin
			du.len_code = 2'd0;
		end else if (raw[63:8] == 56'd0) begin
			du.has_tag  = 1'b1;
			du.tag      = TAG_UINT8;
			du.len_code = 2'd0;
		end else if (raw[63:16] == 48'd0) begin
			du.has_tag  = 1'b1;
			du.tag      = TAG_UINT16;
			du.len_code = 2'd1;
		end else if (raw[63:32] == 32'd0) begin
			du.has_tag  = 1'b1;
			du.tag      = TAG_UINT32;
			du.len_code = 2'd2;
		end else begin
			du.has_tag  = 1'b1;
			du.tag      = TAG_UINT64;
			du.len_code = 2'd3;
		end
	end

	always_comb begin
		d        = '0;
		d.status = ST_OK;
		case (s_tuser)
			KIND_UINT: begin
				d = du;
			end
			KIND_SINT: begin
				if (!sign) begin
					d = du;
				end else if (&ext[63:5]) begin
					// Negative fixint: the low byte of the sign-extended value.
					d.payload = {56'd0, ext[7:0]};
				end else begin
					d.has_tag  = 1'b1;
					d.tag      = 8'(TAG_INT8 + {6'd0, wc});
					d.len_code = wc;
					d.payload  = raw;
				end
			end
			KIND_ARRAY: begin
				if (cnt[7:4] != 4'd0) begin
					d.is_status = 1'b1;
					d.status    = ST_COUNT;
				end else begin
					d.payload = {56'd0, TAG_FIXARRAY | (cnt & FIXARRAY_MASK)};
				end
			end
			KIND_RAW_HDR: begin
				if (cnt[7:5] != 3'd0) begin
					d.is_status = 1'b1;
					d.status    = ST_COUNT;
				end else begin
					d.payload = {56'd0, TAG_FIXRAW | (cnt & FIXRAW_MASK)};
				end
			end
			KIND_RAW_BYTE: begin
				d.payload = {56'd0, val[7:0]};
			end
			default: begin
				d.is_status = 1'b1;
				d.status    = ST_OK;
			end
		endcase
	end

	assign s_tready  = ~q_full;
	assign q_wr.push = s_tvalid & ~q_full;
	assign q_wr.desc = d;

endmodule

`default_nettype wire

@@ rtl/mip_queue.sv @@
// Short descriptor queue that decouples the classifier from the byte sequencer.
// Depends on mip_pkg.
`default_nettype none

module mip_queue #(
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  mip_pkg::q_wr_t   q_wr,
	output logic             q_full,
	input  wire              pop,
	output mip_pkg::q_rd_t   q_rd
);
	import mip_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign q_full     = (count_q == CW'(DEPTH));
	assign q_rd.valid = (count_q != '0);
	assign q_rd.desc  = mem_q[rd_ptr_q];
	assign do_pop     = pop & q_rd.valid;

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wr_ptr_q] <= q_wr.desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (q_wr.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !q_wr.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/mip_back.sv @@
// Back end of the packer: walks one descriptor a byte per cycle while the
// output is free, checks each chunk against the buffer capacity and drives
// the registered output stream. Depends on mip_pkg.
`default_nettype none

module mip_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire  [15:0]      capacity,
	input  mip_pkg::q_rd_t   q_rd,
	output logic             pop,
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [7:0]       m_tdata,
	output logic [2:0]       m_tuser,
	output logic             m_tlast
);
	import mip_pkg::*;

	phase_t      state_q, state_d;
	logic [2:0]  idx_q, idx_d;
	logic [15:0] used_q, used_d;
	logic        can_emit;
	logic        emit;
	logic [7:0]  r_byte;
	logic        r_bv;
	logic        r_last;
	status_t     r_st;
	logic [3:0]  len;
	logic [2:0]  last_idx;
	logic [2:0]  sh;
	logic        fit_tag;
	logic        fit_len;
	logic        pay_step;
	desc_t       d;

	assign d        = q_rd.desc;
	assign can_emit = ~m_tvalid | m_tready;
	assign len      = 4'd1 << d.len_code;
	assign last_idx = 3'(len - 4'd1);
	assign sh       = last_idx - idx_q;
	assign fit_tag  = ({1'b0, used_q} + 17'd1) < {1'b0, capacity};
	assign fit_len  = ({1'b0, used_q} + {13'd0, len}) < {1'b0, capacity};
	assign pay_step = (state_q == PH_PAYLOAD) ||
		(state_q == PH_START && !d.is_status && !d.has_tag);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		used_d  = used_q;
		emit    = 1'b0;
		pop     = 1'b0;
		r_byte  = 8'd0;
		r_bv    = 1'b0;
		r_last  = 1'b0;
		r_st    = ST_OK;
		if (q_rd.valid && can_emit) begin
			emit = 1'b1;
			if (pay_step) begin
				if (idx_q == 3'd0 && !fit_len) begin
					r_st    = ST_FULL;
					r_last  = 1'b1;
					pop     = 1'b1;
					state_d = PH_START;
				end else begin
					r_byte = d.payload[{sh, 3'b000} +: 8];
					r_bv   = 1'b1;
					// The whole payload chunk is counted as soon as it is admitted.
					if (idx_q == 3'd0) begin
						used_d = used_q + {12'd0, len};
					end
					if (idx_q == last_idx) begin
						r_last  = 1'b1;
						pop     = 1'b1;
						idx_d   = 3'd0;
						state_d = PH_START;
					end else begin
						idx_d   = idx_q + 3'd1;
						state_d = PH_PAYLOAD;
					end
				end
			end else if (d.is_status) begin
				r_st   = d.status;
				r_last = 1'b1;
				pop    = 1'b1;
			end else if (fit_tag) begin
				r_byte  = d.tag;
				r_bv    = 1'b1;
				used_d  = used_q + 16'd1;
				idx_d   = 3'd0;
				state_d = PH_PAYLOAD;
			end else begin
				r_st   = ST_FULL;
				r_last = 1'b1;
				pop    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= PH_START;
			idx_q    <= 3'd0;
			used_q   <= 16'd0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			used_q  <= used_d;
			if (emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= r_byte;
			m_tuser <= {r_st, r_bv};
			m_tlast <= r_last;
		end
	end

endmodule

`default_nettype wire

@@ rtl/msgpack_integer_packer.sv @@
// MessagePack integer packer: a request produces 1 to 9 results in the byte sequencer
// (a tag plus up to eight payload bytes).
// From request acceptance, the first result passes through the queue and the output register.
// Throughput is set by the sequencer's single output byte lane: one result per cycle while the receiver keeps up.
// Reset is asynchronous and active low; it clears the queue, the byte count and the
// output valid, and sets the buffer capacity to 256.
`default_nettype none

module msgpack_integer_packer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	// Input requests.
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [79:0] s_tdata,   // [1:0] width_code, [65:2] value, [73:66] count, rest zero
	input  wire  [2:0]  s_tuser,   // [2:0] kind
	// Encoded results, one per cycle at most.
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [2:0]  m_tuser,   // [0] byte_valid, [2:1] status
	output logic        m_tlast,   // last result of the request
	// Buffer capacity register write channel.
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [15:0] cfg_data
);
	import mip_pkg::*;

	q_wr_t       q_wr;
	q_rd_t       q_rd;
	logic        q_full;
	logic        pop;
	logic [15:0] capacity_q;

	// The capacity register is always writable; software must write it only while the
	// packer is idle (unchecked by the block), so the sequencer sees no mid-request change.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	// The classifier turns each request into a descriptor in the same cycle it is
	// accepted. It keeps accepting while the queue has room, so a new request is
	// taken while the sequencer is still emitting bytes of an earlier one.
	mip_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_wr     (q_wr)
	);

	mip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.pop    (pop),
		.q_rd   (q_rd)
	);

	// The sequencer owns the running byte count. Each chunk, the tag and then the
	// payload, is checked against the capacity when it starts; a chunk that does
	// not fit ends the request with a single buffer-full result. The output
	// register is refilled in the same cycle its byte is taken, so bytes stream
	// out one per cycle while the receiver keeps up.
	mip_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.q_rd     (q_rd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
